// File: hdl/rafr_pkg.sv
// ----------------------------------------------------------------------------
// rafr_pkg
// Shared types and constants for the addressed serial frame receiver.
// ----------------------------------------------------------------------------
package rafr_pkg;

  // Framing bytes of the serial protocol.
  localparam logic [7:0] START_BYTE = 8'h3a;
  localparam logic [7:0] END_BYTE   = 8'h0a;

  // Input operation codes.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result event codes.
  localparam logic [1:0] EV_BODY  = 2'd0;
  localparam logic [1:0] EV_GOOD  = 2'd1;
  localparam logic [1:0] EV_BAD   = 2'd2;
  localparam logic [1:0] EV_ABORT = 2'd3;

  // Configuration register indexes (byte address bit 2).
  localparam logic REG_NODE_ADDR = 1'b0;
  localparam logic REG_TIMEOUT   = 1'b1;

  // Reset value of the frame timeout register.
  localparam logic [15:0] TIMEOUT_RESET = 16'd80;

  // Depth of the queue between the front and back stages.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Frame parser phase.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ADDR,
    PH_LEN,
    PH_CMD,
    PH_BODY
  } phase_t;

  // One classified input word as it travels through the queue.
  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
    logic       is_start;
    logic       addr_hit;
    logic       is_end;
  } tok_t;

endpackage

// File: hdl/rafr_front.sv
// ----------------------------------------------------------------------------
// rafr_front
// Input side: accepts words and classifies each byte before it is queued.
// ----------------------------------------------------------------------------
module rafr_front (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_operation,
  input  logic [7:0]           in_rx_byte,
  input  logic [7:0]           node_address,
  input  logic                 q_full,
  output logic                 push,
  output rafr_pkg::tok_t       push_tok
);
  import rafr_pkg::*;

  // The queue is the only reason to hold off the sender.
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Classify the byte against the framing codes and the node address.
  always_comb begin
    push_tok.op       = in_operation;
    push_tok.rx_byte  = in_rx_byte;
    push_tok.is_start = (in_rx_byte == START_BYTE);
    push_tok.addr_hit = (in_rx_byte == node_address);
    push_tok.is_end   = (in_rx_byte == END_BYTE);
  end

endmodule

// File: hdl/rafr_queue.sv
// ----------------------------------------------------------------------------
// rafr_queue
// Short first-in first-out queue of classified words between the two stages.
// ----------------------------------------------------------------------------
module rafr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rafr_pkg::tok_t push_tok,
  input  logic           pop,
  output rafr_pkg::tok_t head_tok,
  output logic           not_empty,
  output logic           full
);
  import rafr_pkg::*;

  tok_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == QCNT_W'(QDEPTH));
  assign head_tok  = mem_r[rd_ptr_r];

  // Occupancy follows push and pop together.
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  // Storage; no reset needed on the payload.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  // The occupancy never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue occupancy beyond depth");

  // A word is only taken from a queue that holds one.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue popped while empty");

endmodule

// File: hdl/rafr_back.sv
// ----------------------------------------------------------------------------
// rafr_back
// Frame state machine, frame timeout and registered result output.
// ----------------------------------------------------------------------------
module rafr_back #(
  parameter int MAX_LEN = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  rafr_pkg::tok_t head_tok,
  output logic           pop,
  input  logic [15:0]    timeout_ticks,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [1:0]     out_event_kind,
  output logic [7:0]     out_body_byte,
  output logic [6:0]     out_byte_index,
  output logic [7:0]     out_frame_command,
  output logic [7:0]     out_frame_length
);
  import rafr_pkg::*;

  // The body counter must reach the declared length plus two.
  localparam int CntW = $clog2(MAX_LEN + 3);

  phase_t          phase_r, phase_nxt;
  logic [7:0]      len_r, len_nxt;
  logic [7:0]      cmd_r, cmd_nxt;
  logic [CntW-1:0] body_cnt_r, body_cnt_nxt;
  logic [15:0]     tcount_r, tcount_nxt;
  logic            armed_r, armed_nxt;

  logic            emit;
  logic [1:0]      ev_kind;
  logic [7:0]      ev_byte;
  logic [6:0]      ev_idx;
  logic [7:0]      ev_cmd;
  logic [7:0]      ev_len;
  logic [15:0]     tcount_inc;
  logic            last_body;

  logic            out_valid_r;
  logic [1:0]      kind_r;
  logic [7:0]      byte_r;
  logic [6:0]      idx_r;
  logic [7:0]      ocmd_r;
  logic [7:0]      olen_r;

  // A word is taken whenever the output register is free or being emptied.
  assign pop = q_valid && (!out_valid_r || !out_stall);

  assign tcount_inc = (tcount_r != 16'hffff) ? tcount_r + 16'd1 : tcount_r;
  assign last_body  = (9'(body_cnt_r) >= ({1'b0, len_r} + 9'd1));

  // Next state and result for the word at the head of the queue.
  always_comb begin
    phase_nxt    = phase_r;
    len_nxt      = len_r;
    cmd_nxt      = cmd_r;
    body_cnt_nxt = body_cnt_r;
    tcount_nxt   = tcount_r;
    armed_nxt    = armed_r;
    emit         = 1'b0;
    ev_kind      = EV_BODY;
    ev_byte      = head_tok.rx_byte;
    ev_idx       = 7'(body_cnt_r);
    ev_cmd       = cmd_r;
    ev_len       = len_r;
    if (head_tok.op == OP_TICK) begin
      // Timer tick: counts only while a frame is open.
      if (armed_r) begin
        tcount_nxt = tcount_inc;
        if (tcount_inc >= timeout_ticks) begin
          emit       = 1'b1;
          ev_kind    = EV_ABORT;
          ev_byte    = 8'd0;
          ev_idx     = (phase_r == PH_BODY) ? 7'(body_cnt_r) : 7'd0;
          phase_nxt  = PH_IDLE;
          armed_nxt  = 1'b0;
          tcount_nxt = 16'd0;
        end
      end
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          if (head_tok.is_start) begin
            phase_nxt    = PH_ADDR;
            len_nxt      = 8'd0;
            cmd_nxt      = 8'd0;
            body_cnt_nxt = '0;
            tcount_nxt   = 16'd0;
            armed_nxt    = 1'b1;
          end
        end
        PH_ADDR: begin
          if (head_tok.addr_hit) begin
            phase_nxt = PH_LEN;
          end else begin
            phase_nxt  = PH_IDLE;
            armed_nxt  = 1'b0;
            tcount_nxt = 16'd0;
          end
        end
        PH_LEN: begin
          len_nxt = head_tok.rx_byte;
          if ({1'b0, head_tok.rx_byte} > 9'(MAX_LEN)) begin
            // Declared length too long: reject the frame straight away.
            emit       = 1'b1;
            ev_kind    = EV_BAD;
            ev_idx     = 7'd0;
            ev_cmd     = 8'd0;
            ev_len     = head_tok.rx_byte;
            phase_nxt  = PH_IDLE;
            armed_nxt  = 1'b0;
            tcount_nxt = 16'd0;
          end else begin
            phase_nxt = PH_CMD;
          end
        end
        PH_CMD: begin
          cmd_nxt      = head_tok.rx_byte;
          body_cnt_nxt = '0;
          phase_nxt    = PH_BODY;
        end
        PH_BODY: begin
          body_cnt_nxt = body_cnt_r + CntW'(1);
          emit         = 1'b1;
          if (last_body) begin
            // Final byte decides between a good and a bad frame.
            ev_kind    = head_tok.is_end ? EV_GOOD : EV_BAD;
            phase_nxt  = PH_IDLE;
            armed_nxt  = 1'b0;
            tcount_nxt = 16'd0;
          end
        end
        default: begin
          phase_nxt  = PH_IDLE;
          armed_nxt  = 1'b0;
          tcount_nxt = 16'd0;
        end
      endcase
    end
  end

  // Parser state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      len_r      <= 8'd0;
      cmd_r      <= 8'd0;
      body_cnt_r <= '0;
      tcount_r   <= 16'd0;
      armed_r    <= 1'b0;
    end else if (pop) begin
      phase_r    <= phase_nxt;
      len_r      <= len_nxt;
      cmd_r      <= cmd_nxt;
      body_cnt_r <= body_cnt_nxt;
      tcount_r   <= tcount_nxt;
      armed_r    <= armed_nxt;
    end
  end

  // Output word valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= emit;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output word payload.
  always_ff @(posedge clk) begin
    if (pop && emit) begin
      kind_r <= ev_kind;
      byte_r <= ev_byte;
      idx_r  <= ev_idx;
      ocmd_r <= ev_cmd;
      olen_r <= ev_len;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_kind    = kind_r;
  assign out_body_byte     = byte_r;
  assign out_byte_index    = idx_r;
  assign out_frame_command = ocmd_r;
  assign out_frame_length  = olen_r;

  // The timeout is armed exactly while a frame is open.
  a_armed_open: assert property (@(posedge clk) disable iff (!rst_n)
    armed_r == (phase_r != PH_IDLE))
    else $error("timeout arming out of step with frame phase");

  // A disarmed timeout holds no stale count.
  a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !armed_r |-> (tcount_r == 16'd0))
    else $error("stale timeout count while disarmed");

  // The body counter never runs past the final byte of the frame.
  a_body_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (9'(body_cnt_r) <= ({1'b0, len_r} + 9'd1)))
    else $error("body counter past frame end");

endmodule

// File: hdl/rs485_addressed_frame_receiver.sv
// ----------------------------------------------------------------------------
// rs485_addressed_frame_receiver
// Addressed serial frame parser with frame timeout.
// ----------------------------------------------------------------------------
// Takes one word per clock while in_stall is low (a received byte or a timer
// tick) and returns at most one result word for each: a streamed body byte
// with its index, a good or bad frame verdict on the final byte, a bad
// verdict on a declared length over MAX_LEN, or a timeout abort. Words are
// classified on entry and placed in a four-word queue; the frame state machine
// in the back stage handles one queued word per clock while results are not
// stalled and writes any result into an output register. With no backlog, a
// result passes through the queue and then the output register. While
// results are stalled, the queue holds up to four words and the output
// register one result. Node address and timeout length are at register port
// byte addresses 0 and 4; the user must write them only while the block is
// idle, which the block does not enforce. No clearing pass follows reset.
module rs485_addressed_frame_receiver #(
  parameter int MAX_LEN = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [7:0]  in_rx_byte,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_kind,
  output logic [7:0]  out_body_byte,
  output logic [6:0]  out_byte_index,
  output logic [7:0]  out_frame_command,
  output logic [7:0]  out_frame_length
);
  import rafr_pkg::*;

  logic [7:0]  node_addr_r;
  logic [15:0] timeout_r;
  logic        cfg_wr;
  logic        q_full;
  logic        q_not_empty;
  logic        q_push;
  logic        q_pop;
  tok_t        push_tok;
  tok_t        head_tok;

  // Register port: pready is held high, so an access never waits.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_addr_r <= 8'd0;
      timeout_r   <= TIMEOUT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_NODE_ADDR: node_addr_r <= pwdata[7:0];
        REG_TIMEOUT:   timeout_r   <= pwdata[15:0];
        default:       node_addr_r <= node_addr_r;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[2])
      REG_NODE_ADDR: prdata = {24'd0, node_addr_r};
      REG_TIMEOUT:   prdata = {16'd0, timeout_r};
      default:       prdata = 32'd0;
    endcase
  end

  // Front stage: accept and classify.
  rafr_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_rx_byte   (in_rx_byte),
    .node_address (node_addr_r),
    .q_full       (q_full),
    .push         (q_push),
    .push_tok     (push_tok)
  );

  // Queue between the stages.
  rafr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_tok  (push_tok),
    .pop       (q_pop),
    .head_tok  (head_tok),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // Back stage: frame state machine and result register.
  rafr_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_not_empty),
    .head_tok          (head_tok),
    .pop               (q_pop),
    .timeout_ticks     (timeout_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_kind    (out_event_kind),
    .out_body_byte     (out_body_byte),
    .out_byte_index    (out_byte_index),
    .out_frame_command (out_frame_command),
    .out_frame_length  (out_frame_length)
  );

endmodule
